@@ rtl/pgd_pkg.sv @@
`default_nettype none

package pgd_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	// padded coordinates up to 4099 fit in 13 bits
	localparam int COORD_W    = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OCC_THRESH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN_PASS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUTSIDE_PROB = 3'd4;

	localparam logic signed [7:0] OCC_UNKNOWN = -8'sd1;

	typedef struct packed {
		logic              frame_start;
		logic signed [7:0] occupancy;
		logic [31:0]       old_prob;
	} in_item_t;

	typedef struct packed {
		logic [31:0] new_prob;
		logic        last_cell;
	} out_item_t;

	typedef struct packed {
		logic [COORD_W-1:0] eff_w;
		logic [COORD_W-1:0] eff_h;
		logic [6:0]         thr;
		logic               unk_pass;
		logic [31:0]        outside_prob;
	} cfg_t;

	// one classified cell on its way from front to back
	typedef struct packed {
		logic signed [7:0]  occupancy;
		logic [31:0]        old_prob;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [2:0]         slot5;
		logic [1:0]         slot4;
		logic               produce;
		logic               last;
	} cell_t;

endpackage

`default_nettype wire

@@ rtl/pgd_front.sv @@
`default_nettype none

module pgd_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire pgd_pkg::in_item_t in_data,
	input  wire pgd_pkg::cfg_t    cfg,
	input  wire logic             q_full,
	output logic                  q_push,
	output pgd_pkg::cell_t        q_data
);
	import pgd_pkg::*;

	logic [COORD_W-1:0] col_q, row_q, pw, ph, cur_col, cur_row, col_inc, row_inc;
	logic [2:0] slot5_q, cur5;
	logic [1:0] slot4_q, cur4;
	logic restart_row, accept;

	assign pw = cfg.eff_w + COORD_W'(4);
	assign ph = cfg.eff_h + COORD_W'(4);
	assign accept = in_valid && !q_full;
	assign in_stall = q_full;
	assign q_push = accept;

	always_comb begin
		restart_row = in_data.frame_start || (row_q >= ph);
		cur_col = (in_data.frame_start || (col_q >= pw)) ? '0 : col_q;
		cur_row = restart_row ? '0 : row_q;
		cur5 = restart_row ? '0 : slot5_q;
		cur4 = restart_row ? '0 : slot4_q;
		col_inc = cur_col + COORD_W'(1);
		row_inc = cur_row + COORD_W'(1);
		q_data.occupancy = in_data.occupancy;
		q_data.old_prob = in_data.old_prob;
		q_data.row = cur_row;
		q_data.col = cur_col;
		q_data.slot5 = cur5;
		q_data.slot4 = cur4;
		q_data.produce = (cur_row >= COORD_W'(4)) && (cur_col >= COORD_W'(4));
		q_data.last = (cur_row == ph - COORD_W'(1)) && (cur_col == pw - COORD_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			slot5_q <= '0;
			slot4_q <= '0;
		end else if (accept) begin
			if (col_inc >= pw) begin
				col_q <= '0;
				if (row_inc >= ph) begin
					row_q <= '0;
					slot5_q <= '0;
					slot4_q <= '0;
				end else begin
					row_q <= row_inc;
					slot5_q <= (cur5 == 3'd4) ? 3'd0 : cur5 + 3'd1;
					slot4_q <= cur4 + 2'd1;
				end
			end else begin
				col_q <= col_inc;
				row_q <= cur_row;
				slot5_q <= cur5;
				slot4_q <= cur4;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/pgd_fifo.sv @@
`default_nettype none

module pgd_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire pgd_pkg::cell_t push_data,
	output logic                full,
	input  wire logic           pop,
	output logic                empty,
	output pgd_pkg::cell_t      head
);
	import pgd_pkg::*;

	cell_t      mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/pgd_div.sv @@
`default_nettype none

module pgd_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [3:0]  divisor,
	output logic             done,
	output logic [31:0]      quotient
);
	logic        busy_q, done_q;
	logic [4:0]  cnt_q;
	logic [31:0] quo_q;
	logic [3:0]  rem_q, dvs_q;
	logic [4:0]  trial, diff;
	logic        fits;

	// restoring division, one quotient bit per cycle
	always_comb begin
		trial = {rem_q, quo_q[31]};
		fits = trial >= {1'b0, dvs_q};
		diff = trial - {1'b0, dvs_q};
	end

	assign done = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[30:0], fits};
			rem_q <= fits ? diff[3:0] : trial[3:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'd31);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/pgd_back.sv @@
`default_nettype none

module pgd_back #(
	parameter int MAX_WIDTH = pgd_pkg::DEF_MAX_WIDTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire pgd_pkg::cfg_t   cfg,
	input  wire logic            q_empty,
	input  wire pgd_pkg::cell_t  q_head,
	output logic                 q_pop,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output pgd_pkg::out_item_t   out_data
);
	import pgd_pkg::*;

	localparam int PAD_W = MAX_WIDTH + 4;
	localparam int OCC_DEPTH = 5 * PAD_W;
	localparam int SHR_DEPTH = 4 * PAD_W;
	localparam int OCC_AW = $clog2(OCC_DEPTH);
	localparam int SHR_AW = $clog2(SHR_DEPTH);
	localparam logic [4:0] WIN_CELLS = 5'd25;
	localparam logic [4:0] WIN_LAST = 5'd24;
	localparam logic [4:0] WIN_CENTRE = 5'd12;
	localparam logic [3:0] SRC_LAST = 4'd8;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_OCC = 3'd1;
	localparam logic [2:0] ST_SRD = 3'd2;
	localparam logic [2:0] ST_SWAIT = 3'd3;
	localparam logic [2:0] ST_DIV = 3'd4;
	localparam logic [2:0] ST_OUT = 3'd5;

	logic signed [7:0] occ_mem [OCC_DEPTH];
	logic [31:0]       shr_mem [SHR_DEPTH];

	logic [2:0]  state_q;
	cell_t       cur_q;
	logic [4:0]  iss_q, pidx_q;
	logic [2:0]  irow_q, icol_q, prow_q, pcol_q;
	logic        pend_q;
	logic [24:0] cnt_q, ins_q, over_q;
	logic        cpass_q;
	logic [3:0]  k_q;
	logic [1:0]  krow_q, kcol_q;
	logic [35:0] sum_q;
	logic signed [7:0] occ_rd_q;
	logic [31:0] shr_rd_q;
	logic        out_valid_q;
	out_item_t   out_data_q;

	logic              occ_re, shr_re;
	logic [OCC_AW-1:0] occ_waddr, occ_raddr;
	logic [SHR_AW-1:0] shr_waddr, shr_raddr;
	logic [3:0]        rs_sum, rs;
	logic [COORD_W-1:0] occ_col, shr_col, win_r, win_c;
	logic [1:0]        shr_slot;
	logic              c_ins, c_pass, c_over;
	logic signed [8:0] occ_x, thr_x;
	logic [4:0]        base, sidx;
	logic [3:0]        n;
	logic [31:0]       src_val;
	logic              skip, div_start, div_done, last_src, out_load;
	logic [31:0]       quo, sat_sum;

	assign q_pop = (state_q == ST_IDLE) && !q_empty;
	assign occ_re = (state_q == ST_OCC) && (iss_q < WIN_CELLS);
	assign shr_re = (state_q == ST_SRD);

	always_comb begin
		occ_waddr = OCC_AW'(q_head.slot5) * OCC_AW'(PAD_W) + OCC_AW'(q_head.col);
		shr_waddr = SHR_AW'(q_head.slot4) * SHR_AW'(PAD_W) + SHR_AW'(q_head.col);
		// window row r-4+i sits in slot (slot5+1+i) mod 5
		rs_sum = {1'b0, cur_q.slot5} + 4'd1 + {1'b0, irow_q};
		rs = (rs_sum >= 4'd5) ? rs_sum - 4'd5 : rs_sum;
		occ_col = cur_q.col - COORD_W'(4) + COORD_W'(icol_q);
		occ_raddr = OCC_AW'(rs) * OCC_AW'(PAD_W) + OCC_AW'(occ_col);
		shr_slot = cur_q.slot4 + 2'd1 + krow_q;
		shr_col = cur_q.col - COORD_W'(3) + COORD_W'(kcol_q);
		shr_raddr = SHR_AW'(shr_slot) * SHR_AW'(PAD_W) + SHR_AW'(shr_col);
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			occ_mem[occ_waddr] <= q_head.occupancy;
			shr_mem[shr_waddr] <= q_head.old_prob;
		end
		if (occ_re) begin
			occ_rd_q <= occ_mem[occ_raddr];
		end
		if (shr_re) begin
			shr_rd_q <= shr_mem[shr_raddr];
		end
	end

	// classify the window cell whose occupancy has just been read
	always_comb begin
		win_r = cur_q.row - COORD_W'(4) + COORD_W'(prow_q);
		win_c = cur_q.col - COORD_W'(4) + COORD_W'(pcol_q);
		c_ins = (win_r >= COORD_W'(2)) && (win_r < cfg.eff_h + COORD_W'(2)) &&
			(win_c >= COORD_W'(2)) && (win_c < cfg.eff_w + COORD_W'(2));
		occ_x = {occ_rd_q[7], occ_rd_q};
		thr_x = {2'b00, cfg.thr};
		c_pass = (occ_x < thr_x) && ((occ_rd_q != OCC_UNKNOWN) || cfg.unk_pass);
		c_over = c_ins && (occ_x > thr_x);
	end

	// divisor: counted cells in the source's 3x3 neighbourhood
	always_comb begin
		base = 5'(krow_q) * 5'd5 + 5'(kcol_q);
		sidx = base + 5'd6;
		n = '0;
		for (int a = 0; a < 3; a++) begin
			for (int b = 0; b < 3; b++) begin
				n = n + 4'(cnt_q[base + 5'(a * 5 + b)]);
			end
		end
		src_val = ins_q[sidx] ? shr_rd_q : cfg.outside_prob;
		skip = over_q[sidx] || (n == 4'd0);
		div_start = (state_q == ST_SWAIT) && !skip;
		last_src = (k_q == SRC_LAST);
		sat_sum = (|sum_q[35:32]) ? '1 : sum_q[31:0];
		out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);
	end

	pgd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (src_val),
		.divisor  (n),
		.done     (div_done),
		.quotient (quo)
	);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end
		if (pend_q) begin
			cnt_q[pidx_q] <= !c_ins || c_pass;
			ins_q[pidx_q] <= c_ins;
			over_q[pidx_q] <= c_over;
			if (pidx_q == WIN_CENTRE) begin
				cpass_q <= c_pass;
			end
		end
		if (out_load) begin
			out_data_q.new_prob <= cpass_q ? sat_sum : '0;
			out_data_q.last_cell <= cur_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iss_q <= '0;
			irow_q <= '0;
			icol_q <= '0;
			pend_q <= 1'b0;
			pidx_q <= '0;
			prow_q <= '0;
			pcol_q <= '0;
			k_q <= '0;
			krow_q <= '0;
			kcol_q <= '0;
			sum_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pend_q <= occ_re;
			if (occ_re) begin
				pidx_q <= iss_q;
				prow_q <= irow_q;
				pcol_q <= icol_q;
				iss_q <= iss_q + 5'd1;
				if (icol_q == 3'd4) begin
					icol_q <= '0;
					irow_q <= irow_q + 3'd1;
				end else begin
					icol_q <= icol_q + 3'd1;
				end
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop && q_head.produce) begin
						state_q <= ST_OCC;
						iss_q <= '0;
						irow_q <= '0;
						icol_q <= '0;
						k_q <= '0;
						krow_q <= '0;
						kcol_q <= '0;
						sum_q <= '0;
					end
				end
				ST_OCC: begin
					if (pend_q && (pidx_q == WIN_LAST)) begin
						state_q <= cpass_q ? ST_SRD : ST_OUT;
					end
				end
				ST_SRD: begin
					state_q <= ST_SWAIT;
				end
				ST_SWAIT, ST_DIV: begin
					if ((state_q == ST_SWAIT && skip) || (state_q == ST_DIV && div_done)) begin
						if (state_q == ST_DIV) begin
							sum_q <= sum_q + 36'(quo);
						end
						if (last_src) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_SRD;
							k_q <= k_q + 4'd1;
							if (kcol_q == 2'd2) begin
								kcol_q <= '0;
								krow_q <= krow_q + 2'd1;
							end else begin
								kcol_q <= kcol_q + 2'd1;
							end
						end
					end else if (state_q == ST_SWAIT) begin
						state_q <= ST_DIV;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule

`default_nettype wire

@@ rtl/probability_grid_diffusion_unit.sv @@
// Channel  Direction  Handshake           Payload
// cfg      in         cfg_we              cfg_index, cfg_data
// in       in         in_valid/in_stall   pgd_pkg::in_item_t
// out      out        out_valid/out_stall pgd_pkg::out_item_t
//
// A padded cell that yields no result is only written into the line buffers by
// the back end; one that yields a grid cell has its 5x5 occupancy window read
// (one line-buffer port) and, if its centre passes, each source read, and each
// source that is divided goes through the bit-serial divider.
// The front end and a two-entry queue take cells while the back end works.
// arst_n clears counters, queue and state; line buffers are not cleared.
`default_nettype none

module probability_grid_diffusion_unit #(
	parameter int MAX_WIDTH  = pgd_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = pgd_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [pgd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [pgd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire pgd_pkg::in_item_t                in_data,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output pgd_pkg::out_item_t                    out_data
);
	import pgd_pkg::*;

	logic [10:0] gw_q, gh_q;
	logic [6:0]  thr_q;
	logic        unk_q;
	logic [31:0] outside_q;
	cfg_t        cfg;
	logic        q_push, q_full, q_pop, q_empty;
	cell_t       q_in, q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q <= 11'd1024;
			gh_q <= 11'd1024;
			thr_q <= 7'd66;
			unk_q <= 1'b1;
			outside_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_WIDTH:   gw_q <= cfg_data[10:0];
				REG_GRID_HEIGHT:  gh_q <= cfg_data[10:0];
				REG_OCC_THRESH:   thr_q <= cfg_data[6:0];
				REG_UNKNOWN_PASS: unk_q <= cfg_data[0];
				REG_OUTSIDE_PROB: outside_q <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (gw_q == 11'd0) begin
			cfg.eff_w = COORD_W'(1);
		end else if (COORD_W'(gw_q) > COORD_W'(MAX_WIDTH)) begin
			cfg.eff_w = COORD_W'(MAX_WIDTH);
		end else begin
			cfg.eff_w = COORD_W'(gw_q);
		end
		if (gh_q == 11'd0) begin
			cfg.eff_h = COORD_W'(1);
		end else if (COORD_W'(gh_q) > COORD_W'(MAX_HEIGHT)) begin
			cfg.eff_h = COORD_W'(MAX_HEIGHT);
		end else begin
			cfg.eff_h = COORD_W'(gh_q);
		end
		cfg.thr = thr_q;
		cfg.unk_pass = unk_q;
		cfg.outside_prob = outside_q;
	end

	pgd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.cfg      (cfg),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_in)
	);

	pgd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	pgd_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

@@ rtl/pgd_chk.sv @@
`default_nettype none

module pgd_chk (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire pgd_pkg::out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_reset_out: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result shown during reset");

	a_reset_in: assert property (@(posedge clk) !arst_n |-> !in_stall)
		else $error("input stalled during reset");

endmodule

bind probability_grid_diffusion_unit pgd_chk u_chk (.*);

`default_nettype wire

@@ test/pgd_checker.sv @@
`timescale 1ns / 1ps

module pgd_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  pgd_pkg::in_item_t  in_data,
	input  logic               out_valid,
	input  logic               out_stall,
	input  pgd_pkg::out_item_t out_data,
	output int                 fail_count,
	output int                 pending
);
	import pgd_pkg::*;

	localparam int MAXW  = DEF_MAX_WIDTH;
	localparam int MAXH  = DEF_MAX_HEIGHT;
	localparam int LINEW = MAXW + 4;

	logic [10:0] width_reg, height_reg;
	logic [6:0]  thr_reg;
	logic        unk_reg;
	logic [31:0] outside_reg;

	logic [7:0]  occ_rows  [5][LINEW];
	logic [31:0] prob_rows [4][LINEW];
	int          col_pos, row_pos, cur_w, cur_h;

	out_item_t   cell_q [$];

	assign pending = cell_q.size();

	function automatic bit in_grid(int r, int c);
		return r >= 2 && r < cur_h + 2 && c >= 2 && c < cur_w + 2;
	endfunction

	function automatic int occ_of(int r, int c);
		return int'($signed(occ_rows[r % 5][c]));
	endfunction

	function automatic bit passable(int r, int c);
		int o;
		o = occ_of(r, c);
		return o < int'(thr_reg) && (o != -1 || unk_reg);
	endfunction

	function automatic logic [31:0] share_sent(int r, int c);
		logic [31:0] val;
		int          n;
		n = 0;
		if (in_grid(r, c)) begin
			if (occ_of(r, c) > int'(thr_reg))
				return '0;
			val = prob_rows[r % 4][c];
		end else begin
			val = outside_reg;
		end
		for (int dr = -1; dr <= 1; dr++)
			for (int dc = -1; dc <= 1; dc++)
				if (!in_grid(r + dr, c + dc) || passable(r + dr, c + dc))
					n++;
		if (n == 0)
			return '0;
		return val / 32'(n);
	endfunction

	task automatic diffuse_cell(in_item_t it);
		int        pw, ph, tr, tc;
		logic [63:0] acc;
		out_item_t res;
		cur_w = width_reg < 1 ? 1 : (width_reg > MAXW ? MAXW : int'(width_reg));
		cur_h = height_reg < 1 ? 1 : (height_reg > MAXH ? MAXH : int'(height_reg));
		pw = cur_w + 4;
		ph = cur_h + 4;
		if (it.frame_start) begin
			col_pos = 0;
			row_pos = 0;
		end
		if (col_pos >= pw) col_pos = 0;
		if (row_pos >= ph) row_pos = 0;
		occ_rows[row_pos % 5][col_pos]  = it.occupancy;
		prob_rows[row_pos % 4][col_pos] = it.old_prob;
		if (row_pos >= 4 && col_pos >= 4) begin
			tr  = row_pos - 2;
			tc  = col_pos - 2;
			acc = '0;
			if (passable(tr, tc)) begin
				for (int dr = -1; dr <= 1; dr++)
					for (int dc = -1; dc <= 1; dc++)
						acc += share_sent(tr + dr, tc + dc);
				if (acc > 64'hFFFF_FFFF)
					acc = 64'hFFFF_FFFF;
			end
			res.new_prob  = acc[31:0];
			res.last_cell = (row_pos == ph - 1 && col_pos == pw - 1);
			cell_q.push_back(res);
		end
		col_pos++;
		if (col_pos >= pw) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= ph)
				row_pos = 0;
		end
	endtask

	task automatic mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s mismatch: expected %h, got %h", $realtime, what, exp_v, got_v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_c;
		if (!arst_n) begin
			width_reg   <= 11'd1024;
			height_reg  <= 11'd1024;
			thr_reg     <= 7'd66;
			unk_reg     <= 1'b1;
			outside_reg <= '0;
			col_pos     = 0;
			row_pos     = 0;
			fail_count  = 0;
			cell_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				REG_GRID_WIDTH:   width_reg   <= cfg_data[10:0];
				REG_GRID_HEIGHT:  height_reg  <= cfg_data[10:0];
				REG_OCC_THRESH:   thr_reg     <= cfg_data[6:0];
				REG_UNKNOWN_PASS: unk_reg     <= cfg_data[0];
				REG_OUTSIDE_PROB: outside_reg <= cfg_data;
				default: ;
				endcase
			end
			if (in_valid && !in_stall)
				diffuse_cell(in_data);
			if (out_valid && !out_stall) begin
				if (cell_q.size() == 0) begin
					mismatch("unexpected transfer", '0, out_data.new_prob);
				end else begin
					exp_c = cell_q.pop_front();
					if (out_data.new_prob !== exp_c.new_prob)
						mismatch("new_prob", exp_c.new_prob, out_data.new_prob);
					if (out_data.last_cell !== exp_c.last_cell)
						mismatch("last_cell", exp_c.last_cell, out_data.last_cell);
				end
			end
		end
	end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import pgd_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;
	logic               in_valid, in_stall;
	in_item_t           in_data;
	logic               out_valid, out_stall;
	out_item_t          out_data;
	int                 fail_count, pending;

	int                 send_idle, recv_idle, hold_go, quiet_cycles, cells_sent;
	logic               in_took;
	logic [6:0]         cur_thr;

	probability_grid_diffusion_unit i_dut (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
	);

	pgd_checker i_checker (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
		.fail_count, .pending
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		in_took <= in_valid && !in_stall;
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= 20000) begin
				$display("[probability_grid_diffusion_unit] ERROR");
				$finish;
			end
		end
	end

	// receiver: random stall, or one long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go != 0) begin
				out_stall <= 1'b1;
				repeat (3000) @(negedge clk);
				hold_go = 0;
			end
			out_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		if (idx == REG_OCC_THRESH)
			cur_thr = val[6:0];
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0 || hold_go != 0) @(negedge clk);
		repeat (400) @(negedge clk);
	endtask

	task automatic set_grid(int w, int h, int thr, bit unk, logic [31:0] outside);
		drain();
		write_reg(REG_GRID_WIDTH, w);
		write_reg(REG_GRID_HEIGHT, h);
		write_reg(REG_OCC_THRESH, thr);
		write_reg(REG_UNKNOWN_PASS, 32'(unk));
		write_reg(REG_OUTSIDE_PROB, outside);
	endtask

	task automatic send_cell(bit fs, logic signed [7:0] occ, logic [31:0] prob);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{frame_start: fs, occupancy: occ, old_prob: prob};
		do @(negedge clk); while (!in_took);
		cells_sent++;
	endtask

	function automatic logic signed [7:0] pick_occ();
		int roll;
		roll = $urandom_range(99);
		if (roll < 15) return OCC_UNKNOWN;
		if (roll < 25) return (cur_thr > 100) ? 8'sd100 : $signed({1'b0, cur_thr});
		if (roll < 32) return 8'sd100;
		if (roll < 40) return 8'sd0;
		return $signed(8'($urandom_range(100)));
	endfunction

	function automatic logic [31:0] pick_prob();
		int roll;
		roll = $urandom_range(9);
		if (roll == 0) return 32'hFFFF_FFFF;
		if (roll == 1) return '0;
		return $urandom;
	endfunction

	// stop_at < 0 runs the whole padded frame
	task automatic send_frame(int w, int h, bit fs, int stop_at);
		int n;
		n = (w + 4) * (h + 4);
		for (int k = 0; k < n; k++) begin
			if (k == stop_at) break;
			send_cell(fs && k == 0, pick_occ(), pick_prob());
		end
	endtask

	initial begin
		int w, h, mode, thr;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		in_data   = '0;
		send_idle = 0;
		recv_idle = 0;
		hold_go   = 0;
		cells_sent = 0;
		cur_thr   = 7'd66;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// writes to indexes past the register list must be ignored
		write_reg(3'd5, 32'hFFFF_FFFF);
		write_reg(3'd7, 32'h0);
		// single-cell grid, fixed extremes
		set_grid(1, 1, 101, 1'b1, 32'hFFFF_FFFF);
		for (int k = 0; k < 25; k++)
			send_cell(k == 0, (k == 12) ? 8'sd100 : OCC_UNKNOWN, 32'hFFFF_FFFF);
		set_grid(2, 2, 0, 1'b0, 32'h8000_0001);
		send_frame(2, 2, 1'b1, -1);
		// width 0 acts as 1, tall grid, partial frame then restart
		set_grid(0, 1024, 50, 1'b1, 32'h1234_5678);
		send_frame(1, 1024, 1'b1, 47);
		// counters left beyond the shrunken frame restart without frame_start
		set_grid(6, 6, 40, 1'b1, 32'h0);
		send_frame(6, 6, 1'b1, 7 * 10 + 8);
		set_grid(2, 2, 40, 1'b1, 32'h0);
		send_frame(2, 2, 1'b0, -1);
		send_frame(2, 2, 1'b0, -1);

		mode = 0;
		while (cells_sent < 1900) begin
			w   = $urandom_range(6, 1);
			h   = $urandom_range(5, 1);
			thr = ($urandom_range(3) == 0) ? (($urandom_range(1) == 0) ? 0 : 101)
				: $urandom_range(101);
			set_grid(w, h, thr, 1'($urandom_range(1)),
				($urandom_range(2) == 0) ? 32'hFFFF_FFFF : $urandom);
			case (mode % 4)
			0: begin send_idle = 0;  recv_idle = 0;  end
			1: begin send_idle = 77; recv_idle = 0;  end
			2: begin send_idle = 0;  recv_idle = 77; end
			default: begin send_idle = 14; recv_idle = 14; end
			endcase
			if (mode == 2) begin
				hold_go = 1;
				@(negedge clk);
			end
			for (int f = 0; f < 3; f++) begin
				if ($urandom_range(9) == 0)
					send_frame(w, h, 1'b1, $urandom_range((w + 4) * (h + 4) - 1, 1));
				else
					send_frame(w, h, (f == 0) || $urandom_range(1), -1);
			end
			mode++;
		end

		drain();
		if (fail_count == 0)
			$display("[probability_grid_diffusion_unit] OK");
		else
			$display("[probability_grid_diffusion_unit] ERROR");
		$finish;
	end

endmodule
